// ----- rtl/sim_pkg.sv -----
// ----------------------------------------------------------------------------
// sim_pkg
// shared types and constants of the selection interval merger
// ----------------------------------------------------------------------------
package sim_pkg;

  localparam int unsigned OUT_BITS = 32;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

endpackage

// ----- rtl/sim_store.sv -----
// ----------------------------------------------------------------------------
// sim_store
// selection store: one write port, one registered read port
// ----------------------------------------------------------------------------
module sim_store
  import sim_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned OB    = 32
) (
  input  logic          clk,
  input  store_ctl_t    ctl,
  input  logic [AW-1:0] wr_addr,
  input  logic [OB-1:0] wr_pos,
  input  logic [OB-1:0] wr_anc,
  input  logic          wr_pri,
  input  logic [AW-1:0] rd_addr,
  output logic [OB-1:0] rd_pos,
  output logic [OB-1:0] rd_anc,
  output logic          rd_pri
);

  logic [2*OB:0] mem [DEPTH];
  logic [2*OB:0] rd_data;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= {wr_pri, wr_anc, wr_pos};
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign rd_pos = rd_data[OB-1:0];
  assign rd_anc = rd_data[2*OB-1:OB];
  assign rd_pri = rd_data[2*OB];

endmodule

// ----- rtl/selection_interval_merger_core.sv -----
// ----------------------------------------------------------------------------
// selection_interval_merger_core
// collects a set of selections, merges overlaps in lower-end order, emits set
// ----------------------------------------------------------------------------
// Selections load at one beat per cycle into the store. The beat with set_end
// closes the set; the block then runs n passes over the n stored entries, each
// pass reading the store once per entry to find the next one in stable
// lower-end order and folding it into a running merged selection. Output
// backpressure can hold a pass in its merge step, and input is not taken
// until the set has been flushed. Beats beyond MAX_SELECTIONS are dropped
// and reported on dropped_flag.
module selection_interval_merger_core
  import sim_pkg::*;
#(
  parameter int unsigned MAX_SELECTIONS = 64,
  parameter int unsigned OFFSET_BITS    = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OUT_BITS-1:0] sel_position,
  input  logic [OUT_BITS-1:0] sel_anchor,
  input  logic                sel_primary,
  input  logic                set_end,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_BITS-1:0] out_position,
  output logic [OUT_BITS-1:0] out_anchor,
  output logic                out_primary,
  output logic                out_last,
  output logic                dropped_flag
);

  localparam int unsigned AW = $clog2(MAX_SELECTIONS);
  localparam int unsigned CW = $clog2(MAX_SELECTIONS + 1);
  localparam int unsigned OB = OFFSET_BITS;
  localparam int unsigned XW = OB + OUT_BITS;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SELECTIONS);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_MERGE = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0]    state;
  logic [CW-1:0] cnt;
  logic          ovf;
  logic          anyp;
  logic          drop;
  logic [CW-1:0] total;
  logic [CW-1:0] pass;
  logic [AW-1:0] idx;
  logic          rv;
  logic [AW-1:0] ridx;
  logic          first;
  logic [OB-1:0] pkey;
  logic [AW-1:0] pidx;
  logic          bf;
  logic [OB-1:0] bkey;
  logic [AW-1:0] bidx;
  logic [OB-1:0] bpos;
  logic [OB-1:0] banc;
  logic          bpri;
  logic          acc_v;
  logic [OB-1:0] acc_pos;
  logic [OB-1:0] acc_anc;
  logic          acc_pri;
  logic          firstout;

  store_ctl_t    ctl;
  logic [AW-1:0] rd_addr;
  logic [OB-1:0] rd_pos;
  logic [OB-1:0] rd_anc;
  logic          rd_pri;
  logic [XW-1:0] in_pos_x;
  logic [XW-1:0] in_anc_x;
  logic [OB-1:0] in_pos;
  logic [OB-1:0] in_anc;
  logic [XW-1:0] acc_pos_x;
  logic [XW-1:0] acc_anc_x;

  logic          in_acc;
  logic          slot_free;
  logic [OB-1:0] rkey;
  logic          cand;
  logic [OB-1:0] acc_lo;
  logic [OB-1:0] acc_hi;
  logic [OB-1:0] b_hi;
  logic [OB-1:0] m_lo;
  logic [OB-1:0] m_hi;
  logic          overlap;
  logic          acc_fwd;
  logic          emit;
  logic          emit_last;
  logic [CW-1:0] cnt_next;

  assign in_pos_x = {{OB{1'b0}}, sel_position};
  assign in_anc_x = {{OB{1'b0}}, sel_anchor};
  assign in_pos   = in_pos_x[OB-1:0];
  assign in_anc   = in_anc_x[OB-1:0];

  assign acc_pos_x = {{OUT_BITS{1'b0}}, acc_pos};
  assign acc_anc_x = {{OUT_BITS{1'b0}}, acc_anc};

  assign in_ready  = (state == S_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  assign ctl.wr_en = in_acc && (cnt < MAX_CNT);
  assign ctl.rd_en = (state == S_SCAN);
  assign rd_addr   = idx;
  assign cnt_next  = ctl.wr_en ? cnt + CW'(1) : cnt;

  sim_store #(
    .DEPTH (MAX_SELECTIONS),
    .AW    (AW),
    .OB    (OB)
  ) u_store (
    .clk     (clk),
    .ctl     (ctl),
    .wr_addr (cnt[AW-1:0]),
    .wr_pos  (in_pos),
    .wr_anc  (in_anc),
    .wr_pri  (sel_primary),
    .rd_addr (rd_addr),
    .rd_pos  (rd_pos),
    .rd_anc  (rd_anc),
    .rd_pri  (rd_pri)
  );

  // candidate for next in stable lower-end order
  assign rkey = (rd_pos < rd_anc) ? rd_pos : rd_anc;
  assign cand = (first || (rkey > pkey) || ((rkey == pkey) && (ridx > pidx)))
                && (!bf || (rkey < bkey));

  // merge of accumulator and chosen entry
  assign acc_lo  = (acc_pos < acc_anc) ? acc_pos : acc_anc;
  assign acc_hi  = (acc_pos > acc_anc) ? acc_pos : acc_anc;
  assign b_hi    = (bpos > banc) ? bpos : banc;
  assign m_lo    = (acc_lo < bkey) ? acc_lo : bkey;
  assign m_hi    = (acc_hi > b_hi) ? acc_hi : b_hi;
  assign overlap = acc_v && (bkey <= acc_hi);
  assign acc_fwd = acc_pos >= acc_anc;

  assign emit      = ((state == S_MERGE) && acc_v && !overlap && slot_free)
                     || ((state == S_FLUSH) && slot_free);
  assign emit_last = (state == S_FLUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      cnt      <= '0;
      ovf      <= 1'b0;
      anyp     <= 1'b0;
      rv       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rv <= (state == S_SCAN);
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            cnt  <= cnt_next;
            anyp <= anyp || (ctl.wr_en && sel_primary);
            if (!ctl.wr_en) begin
              ovf <= 1'b1;
            end
            if (set_end) begin
              if (cnt_next == '0) begin
                cnt <= '0;
                ovf <= 1'b0;
              end else begin
                state <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (CW'(idx) == total - CW'(1)) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          state <= S_MERGE;
        end
        S_MERGE: begin
          if (overlap || !acc_v || slot_free) begin
            if (pass == total - CW'(1)) begin
              state <= S_FLUSH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_FLUSH: begin
          if (slot_free) begin
            state <= S_LOAD;
            cnt   <= '0;
            ovf   <= 1'b0;
            anyp  <= 1'b0;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (emit) begin
      out_position <= acc_pos_x[OUT_BITS-1:0];
      out_anchor   <= acc_anc_x[OUT_BITS-1:0];
      out_primary  <= acc_pri || (firstout && !anyp && (total > CW'(1)));
      out_last     <= emit_last;
      dropped_flag <= drop;
      firstout     <= 1'b0;
    end
    if (rv && cand) begin
      bf   <= 1'b1;
      bkey <= rkey;
      bidx <= ridx;
      bpos <= rd_pos;
      banc <= rd_anc;
      bpri <= rd_pri;
    end
    ridx <= idx;
    unique case (state)
      S_LOAD: begin
        if (in_acc && set_end) begin
          total    <= cnt_next;
          drop     <= ovf || !ctl.wr_en;
          pass     <= '0;
          idx      <= '0;
          first    <= 1'b1;
          bf       <= 1'b0;
          acc_v    <= 1'b0;
          firstout <= 1'b1;
        end
      end
      S_SCAN: begin
        idx <= idx + AW'(1);
      end
      S_WAIT: begin
      end
      S_MERGE: begin
        if (overlap || !acc_v || slot_free) begin
          if (overlap) begin
            acc_anc <= acc_fwd ? m_lo : m_hi;
            acc_pos <= acc_fwd ? m_hi : m_lo;
            acc_pri <= acc_pri || bpri;
          end else begin
            acc_pos <= bpos;
            acc_anc <= banc;
            acc_pri <= bpri;
          end
          acc_v <= 1'b1;
          pkey  <= bkey;
          pidx  <= bidx;
          first <= 1'b0;
          pass  <= pass + CW'(1);
          idx   <= '0;
          bf    <= 1'b0;
        end
      end
      S_FLUSH: begin
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= MAX_CNT)
    else $error("stored count beyond capacity");
  a_best_found: assert property (@(posedge clk) disable iff (rst)
    state == S_MERGE |-> bf)
    else $error("merge step without a chosen entry");
  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && slot_free) |=> (state == S_LOAD && out_valid && out_last))
    else $error("final beat of a set not marked last");
`endif

endmodule
